>>> rtl/core/clte_pkg.sv
// shared types and constants for the character display text buffer engine
// no dependencies; used by clte_dec_unit, clte_text_mem and the top level
`default_nettype none

package clte_pkg;

	localparam int MAG_W = 17;
	localparam int NUM_W = 18;
	localparam int DIG_CNT = 5;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2d;

	localparam logic [7:0] LCD_ROW0_ADDR = 8'h80;
	localparam logic [7:0] LCD_ROW1_ADDR = 8'hc0;
	localparam logic [7:0] LCD_HOME     = 8'h02;
	localparam logic [7:0] LCD_FUNC_SET = 8'h28;
	localparam logic [7:0] LCD_DISP_CLR = 8'h01;
	localparam logic [7:0] LCD_DISP_ON  = 8'h0c;
	localparam logic [7:0] LCD_ENTRY    = 8'h06;

	localparam logic [2:0] INIT_LAST_IDX  = 3'd4;
	localparam logic [2:0] INIT_CLEAR_IDX = 3'd2;

	localparam logic signed [NUM_W-1:0] NUM_MAX = 18'sd99999;
	localparam logic signed [NUM_W-1:0] NUM_MIN = -18'sd99999;

	typedef struct packed {
		logic       valid;
		logic       last_dig;
		logic [3:0] digit;
	} dig_t;

	function automatic logic [MAG_W-1:0] dec_weight(input logic [2:0] k);
		logic [MAG_W-1:0] w;
		case (k)
			3'd0: w = 17'd10000;
			3'd1: w = 17'd1000;
			3'd2: w = 17'd100;
			3'd3: w = 17'd10;
			default: w = 17'd1;
		endcase
		return w;
	endfunction

	function automatic logic [7:0] init_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = LCD_HOME;
			3'd1: b = LCD_FUNC_SET;
			3'd2: b = LCD_DISP_CLR;
			3'd3: b = LCD_DISP_ON;
			default: b = LCD_ENTRY;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/clte_dec_unit.sv
// shared compare and subtract unit that splits a magnitude into decimal digits
// one compare/subtract per cycle, most significant digit first; uses clte_pkg
`default_nettype none

module clte_dec_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [clte_pkg::MAG_W-1:0] mag,
	output clte_pkg::dig_t                  dig
);

	logic                       busy_q;
	logic [2:0]                 k_q;
	logic [clte_pkg::MAG_W-1:0] rem_q;
	logic [3:0]                 cnt_q;
	logic [clte_pkg::MAG_W-1:0] weight;
	logic                       ge;

	assign weight = clte_pkg::dec_weight(k_q);
	assign ge     = (rem_q >= weight);

	always_comb begin
		dig.valid    = busy_q && !ge;
		dig.last_dig = (k_q == 3'(clte_pkg::DIG_CNT - 1));
		dig.digit    = cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
			cnt_q  <= '0;
			rem_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			k_q    <= '0;
			cnt_q  <= '0;
			rem_q  <= mag;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - weight;
				cnt_q <= cnt_q + 4'd1;
			end else begin
				cnt_q <= '0;
				k_q   <= k_q + 3'd1;
				if (dig.last_dig) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		dig.valid |-> (cnt_q <= 4'd9))
		else $error("decimal digit out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(dig.valid && dig.last_dig) |=> !busy_q)
		else $error("digit unit still busy after last digit");

	assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (busy_q && k_q == 3'd0))
		else $error("digit unit did not start");

endmodule

`default_nettype wire

>>> rtl/core/clte_text_mem.sv
// character store: one write port, one registered read port, per-cell valid bits
// a cell that is not valid reads as a space; uses clte_pkg
`default_nettype none

module clte_text_mem #(
	parameter int COLUMNS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [$clog2(2*COLUMNS)-1:0]    wr_addr,
	input  wire logic [7:0]                      wr_data,
	input  wire logic [$clog2(2*COLUMNS)-1:0]    rd_addr,
	output logic      [7:0]                      rd_data,
	input  wire logic                            clr_row_en,
	input  wire logic                            clr_row,
	input  wire logic                            clr_all
);

	localparam int DEPTH = 2 * COLUMNS;

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [7:0]       rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= valid_q[rd_addr] ? mem[rd_addr] : clte_pkg::CH_SPACE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (clr_all) begin
				valid_q <= '0;
			end else if (clr_row_en) begin
				for (int i = 0; i < DEPTH; i++) begin
					if ((i >= COLUMNS) == clr_row) begin
						valid_q[i] <= 1'b0;
					end
				end
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> rtl/core/char_lcd_text_buffer_engine.sv
// top level of the character display text buffer engine: command sequencer,
// cursor, line swap and output word register; uses clte_pkg, clte_dec_unit,
// clte_text_mem
//
// usage: one command word enters on the s_ group (s_tuser = command code,
// s_tdata = row, col, char_code, number, clear_row_after). s_tready is high
// only while the sequencer is idle.
// put char, clear cell, clear line, clear all and swap finish in the accept
// cycle. print number of zero also finishes in the accept cycle; otherwise
// the digit unit does one compare/subtract per cycle, one per digit step.
// refresh emits 2 + 2*COLUMNS words on the m_ group, one per cycle when
// m_tready stays high: command 0x80, row 0, 0xC0, row 1. init emits five
// setup command words, display clear one. m_tuser is 1 for character data,
// m_tlast marks the final word of a command. a stalled m_tready holds the
// output word and the sequencer waits; the store is read through a registered
// port whose address holds while stalled.
// reset: store reads as spaces (per-cell valid bits clear at once), cursor at
// row 1 column 0, no output word pending; no clearing pass is needed.
`default_nettype none

module char_lcd_text_buffer_engine #(
	parameter int COLUMNS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// row[0], col[4:1], char_code[12:5], number[30:13], clear_row_after[32:31]
	input  wire logic [39:0] s_tdata,
	// cmd[3:0]
	input  wire logic [3:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// bus_byte[7:0]
	output logic [7:0]       m_tdata,
	// is_data[0]
	output logic             m_tuser,
	output logic             m_tlast
);

	localparam int CW = $clog2(COLUMNS);
	localparam int AW = $clog2(2 * COLUMNS);
	localparam int MW = CW + 2;
	localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);

	localparam logic [3:0] CMD_PUT   = 4'd0;
	localparam logic [3:0] CMD_NUM   = 4'd1;
	localparam logic [3:0] CMD_CELL  = 4'd2;
	localparam logic [3:0] CMD_LINE  = 4'd3;
	localparam logic [3:0] CMD_ALL   = 4'd4;
	localparam logic [3:0] CMD_SWAP  = 4'd5;
	localparam logic [3:0] CMD_REF   = 4'd6;
	localparam logic [3:0] CMD_INIT  = 4'd7;
	localparam logic [3:0] CMD_DCLR  = 4'd8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NUM,
		ST_REFH,
		ST_REFD,
		ST_CMDS
	} state_t;

	state_t state_q;

	logic                 in_row;
	logic [3:0]           in_col;
	logic [7:0]           in_char;
	logic signed [17:0]   in_num;
	logic [1:0]           in_cra;
	logic [3:0]           in_cmd;
	logic                 accept;

	logic                 cur_row_q;
	logic [CW-1:0]        cur_col_q;
	logic                 swap_q;
	logic                 seen_q;
	logic [2:0]           idx_q;
	logic                 single_q;
	logic                 ref_row_q;
	logic [CW-1:0]        ref_col_q;
	logic                 o_valid_q;
	logic [7:0]           o_byte_q;
	logic                 o_data_q;
	logic                 o_last_q;

	logic [MW-1:0]        col_ext;
	logic [CW-1:0]        col_mod;
	logic signed [17:0]   num_sat;
	logic                 num_neg;
	logic [clte_pkg::MAG_W-1:0] num_mag;

	logic                 eff_row;
	logic [CW-1:0]        eff_col;
	logic                 wr_en;
	logic                 wr_adv;
	logic [7:0]           wr_data;
	logic [AW-1:0]        wr_addr;
	logic                 adv_row;
	logic [CW-1:0]        adv_col;
	logic                 dec_start;
	clte_pkg::dig_t       dig;

	logic                 clr_row_en;
	logic                 clr_row;
	logic                 clr_all;

	logic                 out_go;
	logic [7:0]           out_byte;
	logic                 out_data;
	logic                 out_last;
	logic                 out_free;
	logic                 load;

	logic                 rd_row;
	logic [CW-1:0]        rd_col;
	logic [AW-1:0]        rd_addr;
	logic [7:0]           rd_data;

	function automatic logic [AW-1:0] cell_addr(input logic prow, input logic [CW-1:0] c);
		return prow ? (AW'(COLUMNS) + AW'(c)) : AW'(c);
	endfunction

	assign in_row  = s_tdata[0];
	assign in_col  = s_tdata[4:1];
	assign in_char = s_tdata[12:5];
	assign in_num  = s_tdata[30:13];
	assign in_cra  = s_tdata[32:31];
	assign in_cmd  = s_tuser;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign col_ext = MW'(in_col);
	assign col_mod = (col_ext >= MW'(COLUMNS)) ? CW'(col_ext - MW'(COLUMNS)) : CW'(col_ext);

	always_comb begin
		if (in_num > clte_pkg::NUM_MAX) begin
			num_sat = clte_pkg::NUM_MAX;
		end else if (in_num < clte_pkg::NUM_MIN) begin
			num_sat = clte_pkg::NUM_MIN;
		end else begin
			num_sat = in_num;
		end
		num_neg = num_sat[17];
		num_mag = num_neg ? clte_pkg::MAG_W'(-num_sat) : clte_pkg::MAG_W'(num_sat);
	end

	// cursor placement and store writes
	always_comb begin
		eff_row   = cur_row_q;
		eff_col   = cur_col_q;
		wr_en     = 1'b0;
		wr_adv    = 1'b0;
		wr_data   = clte_pkg::CH_SPACE;
		dec_start = 1'b0;
		if (accept && (in_cmd == CMD_PUT || in_cmd == CMD_NUM || in_cmd == CMD_CELL)) begin
			eff_row = in_row;
			eff_col = col_mod;
		end
		if (accept) begin
			case (in_cmd)
				CMD_PUT: begin
					wr_en   = 1'b1;
					wr_adv  = 1'b1;
					wr_data = in_char;
				end
				CMD_NUM: begin
					if (num_mag == '0) begin
						wr_en   = 1'b1;
						wr_adv  = 1'b1;
						wr_data = clte_pkg::CH_ZERO;
					end else begin
						dec_start = 1'b1;
						if (num_neg) begin
							wr_en   = 1'b1;
							wr_adv  = 1'b1;
							wr_data = clte_pkg::CH_MINUS;
						end
					end
				end
				CMD_CELL: begin
					wr_en = 1'b1;
				end
				default: begin
				end
			endcase
		end else if (state_q == ST_NUM && dig.valid && (dig.digit != 4'd0 || seen_q)) begin
			wr_en   = 1'b1;
			wr_adv  = 1'b1;
			wr_data = clte_pkg::CH_ZERO + {4'd0, dig.digit};
		end
		wr_addr = cell_addr(eff_row ^ swap_q, eff_col);
		if (eff_col == COL_LAST) begin
			adv_col = '0;
			adv_row = ~eff_row;
		end else begin
			adv_col = eff_col + CW'(1);
			adv_row = eff_row;
		end
	end

	always_comb begin
		clr_row_en = 1'b0;
		clr_row    = 1'b0;
		clr_all    = 1'b0;
		if (accept) begin
			case (in_cmd)
				CMD_LINE: begin
					clr_row_en = 1'b1;
					clr_row    = in_row ^ swap_q;
				end
				CMD_ALL, CMD_INIT: begin
					clr_all = 1'b1;
				end
				CMD_SWAP: begin
					clr_row_en = (in_cra[1] == 1'b0);
					clr_row    = in_cra[0] ^ ~swap_q;
				end
				default: begin
				end
			endcase
		end
	end

	// output word source and next store read address
	always_comb begin
		out_go   = 1'b0;
		out_byte = rd_data;
		out_data = 1'b0;
		out_last = 1'b0;
		case (state_q)
			ST_REFH: begin
				out_go   = 1'b1;
				out_byte = ref_row_q ? clte_pkg::LCD_ROW1_ADDR : clte_pkg::LCD_ROW0_ADDR;
			end
			ST_REFD: begin
				out_go   = 1'b1;
				out_data = 1'b1;
				out_last = ref_row_q && (ref_col_q == COL_LAST);
			end
			ST_CMDS: begin
				out_go   = 1'b1;
				out_byte = clte_pkg::init_byte(idx_q);
				out_last = single_q || (idx_q == clte_pkg::INIT_LAST_IDX);
			end
			default: begin
			end
		endcase
	end

	assign out_free = !o_valid_q || m_tready;
	assign load     = out_go && out_free;

	always_comb begin
		rd_row = ref_row_q;
		rd_col = ref_col_q;
		if (load && state_q == ST_REFH) begin
			rd_col = '0;
		end else if (load && state_q == ST_REFD && ref_col_q != COL_LAST) begin
			rd_col = ref_col_q + CW'(1);
		end
		rd_addr = cell_addr(rd_row ^ swap_q, rd_col);
	end

	clte_dec_unit u_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dec_start),
		.mag    (num_mag),
		.dig    (dig)
	);

	clte_text_mem #(
		.COLUMNS (COLUMNS)
	) u_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.clr_row_en (clr_row_en),
		.clr_row    (clr_row),
		.clr_all    (clr_all)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cur_row_q <= 1'b1;
			cur_col_q <= '0;
			swap_q    <= 1'b0;
			seen_q    <= 1'b0;
			idx_q     <= '0;
			single_q  <= 1'b0;
			ref_row_q <= 1'b0;
			ref_col_q <= '0;
			o_valid_q <= 1'b0;
			o_byte_q  <= '0;
			o_data_q  <= 1'b0;
			o_last_q  <= 1'b0;
		end else begin
			if (wr_adv) begin
				cur_row_q <= adv_row;
				cur_col_q <= adv_col;
			end else if (wr_en || dec_start) begin
				cur_row_q <= eff_row;
				cur_col_q <= eff_col;
			end
			if (load) begin
				o_valid_q <= 1'b1;
				o_byte_q  <= out_byte;
				o_data_q  <= out_data;
				o_last_q  <= out_last;
			end else if (m_tready) begin
				o_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_cmd)
							CMD_NUM: begin
								seen_q <= 1'b0;
								if (dec_start) begin
									state_q <= ST_NUM;
								end
							end
							CMD_LINE: begin
								cur_row_q <= in_row;
							end
							CMD_ALL: begin
								cur_row_q <= 1'b1;
								cur_col_q <= '0;
							end
							CMD_SWAP: begin
								swap_q <= ~swap_q;
								if (in_cra[1] == 1'b0) begin
									cur_row_q <= in_cra[0];
								end
							end
							CMD_REF: begin
								state_q   <= ST_REFH;
								ref_row_q <= 1'b0;
								ref_col_q <= '0;
							end
							CMD_INIT: begin
								cur_row_q <= 1'b1;
								cur_col_q <= '0;
								state_q   <= ST_CMDS;
								idx_q     <= '0;
								single_q  <= 1'b0;
							end
							CMD_DCLR: begin
								state_q  <= ST_CMDS;
								idx_q    <= clte_pkg::INIT_CLEAR_IDX;
								single_q <= 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
				ST_NUM: begin
					if (wr_en) begin
						seen_q <= 1'b1;
					end
					if (dig.valid && dig.last_dig) begin
						state_q <= ST_IDLE;
					end
				end
				ST_REFH: begin
					if (load) begin
						state_q   <= ST_REFD;
						ref_col_q <= '0;
					end
				end
				ST_REFD: begin
					if (load) begin
						if (ref_col_q == COL_LAST) begin
							if (ref_row_q) begin
								state_q <= ST_IDLE;
							end else begin
								state_q   <= ST_REFH;
								ref_row_q <= 1'b1;
							end
						end else begin
							ref_col_q <= ref_col_q + CW'(1);
						end
					end
				end
				ST_CMDS: begin
					if (load) begin
						if (out_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata  = o_byte_q;
	assign m_tuser  = o_data_q;
	assign m_tlast  = o_last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		dig.valid |-> (state_q == ST_NUM))
		else $error("digit produced outside number printing");

	assert property (@(posedge clk) disable iff (!arst_n)
		(load && out_last) |=> (state_q == ST_IDLE))
		else $error("sequencer busy after last word");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REFD) |-> (ref_col_q <= COL_LAST))
		else $error("refresh column out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && clr_all) |-> 1'b0)
		else $error("store write during clear all");

endmodule

`default_nettype wire
